>>> src/swc_pkg.sv
// Shared types and constants for the segment wall clipper.
// No dependencies; used by swc_if.sv, swc_alu.sv and the top level.
package swc_pkg;

  localparam int WALLS_DEF = 16;
  localparam int COORD_W   = 32;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int CFG_W     = 5;
  localparam int SLOT_W    = 4;
  localparam int ALU_W     = 104;
  localparam int MUL_BITS  = DIFF_W;
  localparam int CNT_W     = $clog2(ALU_W);

  typedef enum logic {KIND_WALL = 1'b0, KIND_RAY = 1'b1} kind_t;

  typedef struct packed {
    logic                    start;
    logic                    div;
    logic signed [ALU_W-1:0] a;
    logic signed [ALU_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic                    done;
    logic                    busy;
    logic signed [ALU_W-1:0] res;
  } alu_rsp_t;

endpackage

>>> src/swc_if.sv
// Valid/ready channel interfaces for ray and wall transactions and results.
// Depends on swc_pkg.
interface swc_in_if import swc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      kind;
  logic [SLOT_W-1:0]         wall_slot;
  logic signed [COORD_W-1:0] first_x;
  logic signed [COORD_W-1:0] first_y;
  logic signed [COORD_W-1:0] second_x;
  logic signed [COORD_W-1:0] second_y;

  modport source (output valid, kind, wall_slot, first_x, first_y, second_x, second_y,
                  input ready);
  modport sink (input valid, kind, wall_slot, first_x, first_y, second_x, second_y,
                output ready);
endinterface

interface swc_out_if import swc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      hit;
  logic signed [COORD_W-1:0] end_x;
  logic signed [COORD_W-1:0] end_y;

  modport source (output valid, hit, end_x, end_y, input ready);
  modport sink (input valid, hit, end_x, end_y, output ready);
endinterface

>>> src/swc_alu.sv
// Shared serial arithmetic unit: shift-add multiply (one multiplier bit a cycle)
// and restoring truncating divide (one quotient bit a cycle). Depends on swc_pkg.
module swc_alu import swc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_PREP = 3'd1;
  localparam logic [2:0] PH_RUN  = 3'd2;
  localparam logic [2:0] PH_FIX  = 3'd3;
  localparam logic [2:0] PH_DONE = 3'd4;

  logic [2:0]              phase;
  logic                    is_div;
  logic                    neg;
  logic [CNT_W-1:0]        cnt;
  logic signed [ALU_W-1:0] acc;
  logic [ALU_W-1:0]        sh;
  logic [ALU_W-1:0]        qb;
  logic [ALU_W:0]          rem_sh;
  logic [ALU_W:0]          trial;

  assign rem_sh = {acc, sh[ALU_W-1]};
  assign trial  = rem_sh - {1'b0, qb};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
    end else begin
      unique case (phase) inside
        PH_IDLE, PH_DONE: begin
          if (req.start) begin
            is_div <= req.div;
            sh     <= req.a;
            qb     <= req.b;
            acc    <= '0;
            cnt    <= '0;
            phase  <= req.div ? PH_PREP : PH_RUN;
          end else begin
            phase <= PH_IDLE;
          end
        end
        PH_PREP: begin
          neg   <= sh[ALU_W-1] ^ qb[ALU_W-1];
          sh    <= sh[ALU_W-1] ? -sh : sh;
          qb    <= qb[ALU_W-1] ? -qb : qb;
          phase <= PH_RUN;
        end
        PH_RUN: begin
          cnt <= cnt + 1'b1;
          if (!is_div) begin
            if (qb[0]) begin
              acc <= (cnt == CNT_W'(MUL_BITS-1)) ? acc - $signed(sh) : acc + $signed(sh);
            end
            sh <= {sh[ALU_W-2:0], 1'b0};
            qb <= {1'b0, qb[ALU_W-1:1]};
            if (cnt == CNT_W'(MUL_BITS-1)) phase <= PH_DONE;
          end else begin
            acc <= trial[ALU_W] ? rem_sh[ALU_W-1:0] : trial[ALU_W-1:0];
            sh  <= {sh[ALU_W-2:0], ~trial[ALU_W]};
            if (cnt == CNT_W'(ALU_W-1)) phase <= PH_FIX;
          end
        end
        PH_FIX: begin
          acc   <= neg ? -$signed(sh) : $signed(sh);
          phase <= PH_DONE;
        end
        default: phase <= PH_IDLE;
      endcase
    end
  end

  assign rsp.done = (phase == PH_DONE);
  assign rsp.busy = (phase != PH_IDLE) && (phase != PH_DONE);
  assign rsp.res  = acc;

endmodule

>>> src/segment_wall_clipper_top.sv
// Segment wall clipper: wall table plus per-wall intersection sequencer.
// Wall load: stored in the table, no result. Ray: a wall that needs no arithmetic is skipped at
// once; a vertical case takes one multiply and one divide, a slanted wall up to 8 serial
// multiplies and 2 divides on the one shared unit in swc_alu. One transaction at a time; ready
// only while idle. Sync reset clears control and wall_count; the wall table is not cleared.
module segment_wall_clipper_top import swc_pkg::*; #(
  parameter int WALLS = WALLS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_data,
  swc_in_if.sink           in_item,
  swc_out_if.source        out_item
);

  localparam int AW = (WALLS > 1) ? $clog2(WALLS) : 1;
  localparam int CW = $clog2(WALLS + 1);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_NEXT = 5'd1;
  localparam logic [4:0] S_RD   = 5'd2;
  localparam logic [4:0] S_VR_M = 5'd3;
  localparam logic [4:0] S_VR_D = 5'd4;
  localparam logic [4:0] S_VW_M = 5'd5;
  localparam logic [4:0] S_VW_D = 5'd6;
  localparam logic [4:0] S_M1   = 5'd7;
  localparam logic [4:0] S_M2   = 5'd8;
  localparam logic [4:0] S_P12  = 5'd9;
  localparam logic [4:0] S_N1   = 5'd10;
  localparam logic [4:0] S_N2   = 5'd11;
  localparam logic [4:0] S_N3   = 5'd12;
  localparam logic [4:0] S_N4   = 5'd13;
  localparam logic [4:0] S_XD   = 5'd14;
  localparam logic [4:0] S_YM   = 5'd15;
  localparam logic [4:0] S_YD   = 5'd16;
  localparam logic [4:0] S_FIN  = 5'd17;
  localparam logic [4:0] S_OUT  = 5'd18;

  logic [4:0]                state, state_next;
  logic [CFG_W-1:0]          wall_count;
  logic [CW-1:0]             n_sat;
  logic [CW-1:0]             wi;
  logic [4*COORD_W-1:0]      mem [WALLS];
  logic [4*COORD_W-1:0]      rd;
  logic signed [COORD_W-1:0] ax, ay, cx, cy;
  logic signed [COORD_W-1:0] w_x1, w_y1, w_x2, w_y2;
  logic signed [COORD_W-1:0] wxl, wxh, wyl, wyh, rxl, rxh, ryl, ryh;
  logic signed [DIFF_W-1:0]  dx1, dy1, dx2, dy2;
  logic signed [ALU_W-1:0]   m1, m2, p12, num, cand_y, yw;
  logic signed [COORD_W-1:0] cand_x;
  logic                      hit;
  logic                      out_valid, out_hit;
  logic signed [COORD_W-1:0] out_x, out_y;
  logic                      in_acc, done, vr_ok, vw_ok, xw_ok, box_ok;
  logic signed [ALU_W-1:0]   res;
  alu_req_t                  alu_req;
  alu_rsp_t                  alu_rsp;

  swc_alu u_alu (.clk(clk), .rst(rst), .req(alu_req), .rsp(alu_rsp));

  assign done = alu_rsp.done;
  assign res  = alu_rsp.res;

  assign in_item.ready  = (state == S_IDLE);
  assign in_acc         = in_item.valid && in_item.ready;
  assign out_item.valid = out_valid;
  assign out_item.hit   = out_hit;
  assign out_item.end_x = out_x;
  assign out_item.end_y = out_y;

  assign n_sat = (int'(wall_count) > WALLS) ? CW'(WALLS) : CW'(wall_count);

  assign w_x1 = rd[4*COORD_W-1:3*COORD_W];
  assign w_y1 = rd[3*COORD_W-1:2*COORD_W];
  assign w_x2 = rd[2*COORD_W-1:COORD_W];
  assign w_y2 = rd[COORD_W-1:0];

  assign dx1 = DIFF_W'(cx) - DIFF_W'(ax);
  assign dy1 = DIFF_W'(cy) - DIFF_W'(ay);
  assign dx2 = DIFF_W'(w_x2) - DIFF_W'(w_x1);
  assign dy2 = DIFF_W'(w_y2) - DIFF_W'(w_y1);

  assign wxl = (w_x1 < w_x2) ? w_x1 : w_x2;
  assign wxh = (w_x1 < w_x2) ? w_x2 : w_x1;
  assign wyl = (w_y1 < w_y2) ? w_y1 : w_y2;
  assign wyh = (w_y1 < w_y2) ? w_y2 : w_y1;
  assign rxl = (ax < cx) ? ax : cx;
  assign rxh = (ax < cx) ? cx : ax;
  assign ryl = (ay < cy) ? ay : cy;
  assign ryh = (ay < cy) ? cy : ay;

  assign yw     = ALU_W'(ay) + res;
  assign vr_ok  = (ax >= wxl) && (ax <= wxh);
  assign vw_ok  = (yw >= ALU_W'(wyl)) && (yw <= ALU_W'(wyh));
  assign xw_ok  = (res >= ALU_W'(wxl)) && (res <= ALU_W'(wxh)) &&
                  (res >= ALU_W'(rxl)) && (res <= ALU_W'(rxh));
  assign box_ok = (cand_x >= rxl) && (cand_x <= rxh) &&
                  (cand_y >= ALU_W'(ryl)) && (cand_y <= ALU_W'(ryh));

  always_comb begin
    state_next    = state;
    alu_req       = '0;
    unique case (state)
      S_IDLE: if (in_acc && in_item.kind == KIND_RAY) state_next = S_NEXT;
      S_NEXT: state_next = (wi == n_sat) ? S_OUT : S_RD;
      S_RD: begin
        if (dx1 == '0 && dx2 == '0) begin
          state_next = S_NEXT;
        end else if (dx1 == '0) begin
          if (vr_ok) begin
            alu_req.start = 1'b1;
            alu_req.a     = ALU_W'(dy2);
            alu_req.b     = ALU_W'(DIFF_W'(ax) - DIFF_W'(w_x1));
            state_next    = S_VR_M;
          end else begin
            state_next = S_NEXT;
          end
        end else if (dx2 == '0) begin
          alu_req.start = 1'b1;
          alu_req.a     = ALU_W'(dy1);
          alu_req.b     = ALU_W'(DIFF_W'(w_x1) - DIFF_W'(ax));
          state_next    = S_VW_M;
        end else begin
          alu_req.start = 1'b1;
          alu_req.a     = ALU_W'(dy1);
          alu_req.b     = ALU_W'(dx2);
          state_next    = S_M1;
        end
      end
      S_VR_M: if (done) begin
        alu_req.start = 1'b1;
        alu_req.div   = 1'b1;
        alu_req.a     = res;
        alu_req.b     = ALU_W'(dx2);
        state_next    = S_VR_D;
      end
      S_VR_D: if (done) state_next = S_FIN;
      S_VW_M: if (done) begin
        alu_req.start = 1'b1;
        alu_req.div   = 1'b1;
        alu_req.a     = res;
        alu_req.b     = ALU_W'(dx1);
        state_next    = S_VW_D;
      end
      S_VW_D: if (done) state_next = vw_ok ? S_FIN : S_NEXT;
      S_M1: if (done) begin
        alu_req.start = 1'b1;
        alu_req.a     = ALU_W'(dy2);
        alu_req.b     = ALU_W'(dx1);
        state_next    = S_M2;
      end
      S_M2: if (done) begin
        alu_req.start = 1'b1;
        alu_req.a     = ALU_W'(dx1);
        alu_req.b     = ALU_W'(dx2);
        state_next    = S_P12;
      end
      S_P12: if (done) begin
        if (m1 == m2) begin
          state_next = S_NEXT;
        end else begin
          alu_req.start = 1'b1;
          alu_req.a     = m1;
          alu_req.b     = ALU_W'(ax);
          state_next    = S_N1;
        end
      end
      S_N1: if (done) begin
        alu_req.start = 1'b1;
        alu_req.a     = p12;
        alu_req.b     = ALU_W'(ay);
        state_next    = S_N2;
      end
      S_N2: if (done) begin
        alu_req.start = 1'b1;
        alu_req.a     = m2;
        alu_req.b     = ALU_W'(w_x1);
        state_next    = S_N3;
      end
      S_N3: if (done) begin
        alu_req.start = 1'b1;
        alu_req.a     = p12;
        alu_req.b     = ALU_W'(w_y1);
        state_next    = S_N4;
      end
      S_N4: if (done) begin
        alu_req.start = 1'b1;
        alu_req.div   = 1'b1;
        alu_req.a     = num + res;
        alu_req.b     = m1 - m2;
        state_next    = S_XD;
      end
      S_XD: if (done) begin
        if (xw_ok) begin
          alu_req.start = 1'b1;
          alu_req.a     = ALU_W'(dy1);
          alu_req.b     = ALU_W'(DIFF_W'($signed(res[COORD_W-1:0])) - DIFF_W'(ax));
          state_next    = S_YM;
        end else begin
          state_next = S_NEXT;
        end
      end
      S_YM: if (done) begin
        alu_req.start = 1'b1;
        alu_req.div   = 1'b1;
        alu_req.a     = res;
        alu_req.b     = ALU_W'(dx1);
        state_next    = S_YD;
      end
      S_YD: if (done) state_next = S_FIN;
      S_FIN: state_next = S_NEXT;
      S_OUT: if (out_item.ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_item.kind == KIND_WALL && int'(in_item.wall_slot) < WALLS) begin
      mem[AW'(in_item.wall_slot)] <= {in_item.first_x, in_item.first_y,
                                      in_item.second_x, in_item.second_y};
    end
    if (state == S_NEXT) rd <= mem[wi[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      wall_count <= '0;
      out_valid  <= 1'b0;
      hit        <= 1'b0;
      wi         <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) wall_count <= cfg_data;
      if (state == S_IDLE) begin
        if (in_acc && in_item.kind == KIND_RAY) begin
          ax  <= in_item.first_x;
          ay  <= in_item.first_y;
          cx  <= in_item.second_x;
          cy  <= in_item.second_y;
          wi  <= '0;
          hit <= 1'b0;
        end
      end else if (state_next == S_NEXT) begin
        wi <= wi + 1'b1;
      end
      case (state) inside
        S_NEXT: if (wi == n_sat) begin
          out_valid <= 1'b1;
          out_hit   <= hit;
          out_x     <= cx;
          out_y     <= cy;
        end
        S_OUT: if (out_item.ready) out_valid <= 1'b0;
        S_M1:  if (done) m1 <= res;
        S_M2:  if (done) m2 <= res;
        S_P12: if (done) p12 <= res;
        S_N1:  if (done) num <= res;
        S_N2, S_N3: if (done) num <= num - res;
        S_VR_D: if (done) begin
          cand_x <= ax;
          cand_y <= ALU_W'(w_y1) + res;
        end
        S_VW_D: if (done) begin
          cand_x <= w_x1;
          cand_y <= yw;
        end
        S_XD: if (done) cand_x <= res[COORD_W-1:0];
        S_YD: if (done) cand_y <= ALU_W'(ay) + res;
        S_FIN: if (box_ok) begin
          cx  <= cand_x;
          cy  <= cand_y[COORD_W-1:0];
          hit <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  a_ready_excl: assert property (@(posedge clk) disable iff (rst)
    in_item.ready |-> !out_item.valid)
    else $error("input ready while a result is pending");

  a_alu_free: assert property (@(posedge clk) disable iff (rst)
    alu_req.start |-> !alu_rsp.busy)
    else $error("arithmetic unit started while busy");

  a_wi_range: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE && state != S_OUT) |-> (wi <= n_sat))
    else $error("wall index past wall count");

  a_hit_src: assert property (@(posedge clk) disable iff (rst)
    $rose(hit) |-> ($past(state) == S_FIN))
    else $error("hit set outside the commit step");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT) |-> out_item.valid)
    else $error("result dropped before transaction");

endmodule
